[design/afr_pkg.sv]
// Package for the frame receiver: word types, status codes and register indexes.
// Depends on nothing. Used by every module in the design folder.
package afr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 9;
	localparam int unsigned CFG_IDX_W = 1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADSUM  = 2'd1,
		ST_TIMEOUT = 2'd2,
		ST_TOOLONG = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_BYTE = 1'b0,
		CFG_MAX_LENGTH = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] rx_byte;
	} in_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  data_byte;
		logic [INDEX_W-1:0] byte_index;
		logic               is_last;
		status_t            status;
	} out_word_t;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd59;
	localparam logic [BYTE_W-1:0] MAX_LENGTH_RST = 8'd255;

endpackage

[design/afr_frame_fsm.sv]
// Frame phase machine: takes one registered word per cycle while item_valid is high and forms its result.
// Depends on afr_pkg.
module afr_frame_fsm (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  afr_pkg::in_word_t         item,
	input  logic [afr_pkg::BYTE_W-1:0] start_byte,
	input  logic [afr_pkg::BYTE_W-1:0] max_length,
	output logic                      res_valid,
	output afr_pkg::out_word_t        res
);
	import afr_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2,
		PH_CHK  = 2'd3
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [BYTE_W-1:0]   bytes_left_q, bytes_left_d;
	logic [BYTE_W-1:0]   sum_q, sum_d;
	logic [INDEX_W-1:0]  position_q, position_d;
	logic [INDEX_W-1:0]  pos_inc;
	logic [BYTE_W-1:0]   expect_sum;
	logic [BYTE_W-1:0]   b;

	assign b          = item.rx_byte;
	assign pos_inc    = position_q + INDEX_W'(1);
	assign expect_sum = BYTE_W'(0) - sum_q;

	always_comb begin
		phase_d          = phase_q;
		bytes_left_d     = bytes_left_q;
		sum_d            = sum_q;
		position_d       = position_q;
		res_valid        = 1'b0;
		res.data_byte    = b;
		res.byte_index   = position_q;
		res.is_last      = 1'b0;
		res.status       = ST_OK;
		if (item.kind) begin
			res_valid      = 1'b1;
			res.data_byte  = '0;
			res.is_last    = 1'b1;
			res.status     = ST_TIMEOUT;
			phase_d        = PH_HUNT;
			bytes_left_d   = '0;
			sum_d          = '0;
			position_d     = '0;
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (b == start_byte) begin
						phase_d    = PH_LEN;
						position_d = '0;
						sum_d      = '0;
					end
				end
				PH_LEN: begin
					res_valid      = 1'b1;
					res.byte_index = '0;
					position_d     = '0;
					if (b > max_length) begin
						res.is_last  = 1'b1;
						res.status   = ST_TOOLONG;
						phase_d      = PH_HUNT;
						bytes_left_d = '0;
						sum_d        = '0;
					end else begin
						sum_d        = b;
						bytes_left_d = b;
						phase_d      = (b == '0) ? PH_CHK : PH_DATA;
					end
				end
				PH_DATA: begin
					res_valid      = 1'b1;
					res.byte_index = pos_inc;
					sum_d          = sum_q + b;
					position_d     = pos_inc;
					bytes_left_d   = bytes_left_q - BYTE_W'(1);
					if (bytes_left_q == BYTE_W'(1)) begin
						phase_d = PH_CHK;
					end
				end
				PH_CHK: begin
					res_valid      = 1'b1;
					res.byte_index = pos_inc;
					res.is_last    = 1'b1;
					res.status     = (b == expect_sum) ? ST_OK : ST_BADSUM;
					phase_d        = PH_HUNT;
					bytes_left_d   = '0;
					sum_d          = '0;
					position_d     = '0;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
		if (!item_valid) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			bytes_left_q <= '0;
			sum_q        <= '0;
			position_q   <= '0;
		end else if (item_valid) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			sum_q        <= sum_d;
			position_q   <= position_d;
		end
	end

endmodule

[design/afr_out_queue.sv]
// Two-entry result queue that decouples the phase machine from a stalling receiver.
// Depends on afr_pkg.
module afr_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  afr_pkg::out_word_t push_word,
	output logic               full,
	output logic               res_valid,
	input  logic               res_stall,
	output afr_pkg::out_word_t res_word
);
	import afr_pkg::*;

	out_word_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign res_valid = (count_q != 2'd0);
	assign res_word  = entry_q[rd_ptr_q];
	assign pop       = res_valid && !res_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/aux_frame_receiver.sv]
// Top level of the serial frame receiver: input register, configuration registers,
// phase machine and result queue. Depends on afr_pkg, afr_frame_fsm and afr_out_queue.
//
// Usage: the rx channel carries one word per received event, either a byte from the
// serial line or a receive timeout. The res channel gives one word for each frame
// byte after the start byte (length, payload, checksum) and one for each timeout.
// Both channels move a word at a rising edge where valid is high and stall is low.
// A word accepted at one edge is written into the input register; the phase machine
// processes it when the queue is not full, and any result is registered in the queue,
// from which it shows on res. Throughput: one word per cycle unless the queue is full.
// When the receiver stalls, the two-entry result queue absorbs results; once it is
// full and a word waits in the input register, rx_stall rises until an entry drains.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at once
// and are meant for an idle block. Reset clears the phase machine to hunting for
// the start byte, empties the queue and loads start byte 59 and max length 255.
module aux_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rx_valid,
	output logic                          rx_stall,
	input  afr_pkg::in_word_t             rx_word,
	output logic                          res_valid,
	input  logic                          res_stall,
	output afr_pkg::out_word_t            res_word,
	input  logic                          cfg_we,
	input  logic [afr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [afr_pkg::BYTE_W-1:0]    cfg_data
);
	import afr_pkg::*;

	logic              item_vld_s1;
	in_word_t          item_s1;
	logic [BYTE_W-1:0] start_byte_q;
	logic [BYTE_W-1:0] max_length_q;
	logic              q_full;
	logic              advance;
	logic              fsm_res_valid;
	out_word_t         fsm_res;

	assign advance  = item_vld_s1 && !q_full;
	assign rx_stall = item_vld_s1 && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (!rx_stall) begin
			item_vld_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			item_s1 <= rx_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_BYTE: start_byte_q <= cfg_data;
				CFG_MAX_LENGTH: max_length_q <= cfg_data;
				default:        start_byte_q <= start_byte_q;
			endcase
		end
	end

	afr_frame_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (advance),
		.item       (item_s1),
		.start_byte (start_byte_q),
		.max_length (max_length_q),
		.res_valid  (fsm_res_valid),
		.res        (fsm_res)
	);

	afr_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fsm_res_valid),
		.push_word (fsm_res),
		.full      (q_full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule
